/* design/stg_pkg.sv */
// Shared constants and types for the square tone generator.
package stg_pkg;

  // Codes carried in the action field of a command word.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  // Fixed arithmetic constants.
  localparam logic [14:0] TONE_RATE  = 15'd22050;
  localparam logic [15:0] MS_PER_SEC = 16'd1000;
  localparam logic [8:0]  AMP_STEP   = 9'd300;
  localparam logic [6:0]  VOL_MAX    = 7'd100;
  localparam logic [14:0] MIN_PERIOD = 15'd2;

  // Divider geometry: the widest dividend is 22050 * 65535, which needs 31 bits.
  localparam int unsigned QUO_W = 31;
  localparam int unsigned CNT_W = $clog2(QUO_W);

  typedef struct packed {
    logic             start;
    logic [QUO_W-1:0] dividend;
    logic [15:0]      divisor;
  } stg_div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } stg_div_rsp_t;

  typedef struct packed {
    logic        valid;
    logic [14:0] period;
    logic [20:0] samples;
    logic [14:0] amp;
  } stg_load_t;

  typedef struct packed {
    logic signed [15:0] value;
    logic               valid;
    logic               last;
  } stg_sample_t;

endpackage

/* design/stg_ifs.sv */
// Valid/ready channel interfaces for command words and sample words.
interface stg_cmd_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] tone_freq;
  logic [15:0] tone_length_ms;
  logic [7:0]  loudness;

  modport source (output valid, action, tone_freq, tone_length_ms, loudness, input ready);
  modport sink   (input valid, action, tone_freq, tone_length_ms, loudness, output ready);
endinterface

interface stg_smp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic               sample_valid;
  logic               last_sample;

  modport source (output valid, left_sample, right_sample, sample_valid, last_sample,
                  input ready);
  modport sink   (input valid, left_sample, right_sample, sample_valid, last_sample,
                  output ready);
endinterface

/* design/stg_div.sv */
// Shared restoring divider, one quotient bit per cycle.
module stg_div (
  input  logic                 clk,
  input  logic                 rst,
  input  stg_pkg::stg_div_req_t req,
  output stg_pkg::stg_div_rsp_t rsp
);

  logic                          busy;
  logic                          done;
  logic [stg_pkg::CNT_W-1:0]     cnt;
  logic [15:0]                   rem;
  logic [stg_pkg::QUO_W-1:0]     quo;
  logic [15:0]                   dvs;
  logic [16:0]                   shifted;
  logic [17:0]                   diff;

  assign shifted = {rem, quo[stg_pkg::QUO_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= stg_pkg::CNT_W'(stg_pkg::QUO_W - 1);
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        if (!diff[17]) begin
          rem <= diff[15:0];
          quo <= {quo[stg_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem <= shifted[15:0];
          quo <= {quo[stg_pkg::QUO_W-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* design/stg_voice.sv */
// Tone state: sample counter, phase counter and square-wave sample.
module stg_voice (
  input  logic                clk,
  input  logic                rst,
  input  stg_pkg::stg_load_t  load,
  input  logic                tick,
  output stg_pkg::stg_sample_t smp
);

  logic [20:0] samples_left;
  logic [14:0] period_len;
  logic [14:0] phase_count;
  logic [14:0] amp_level;
  logic        tone_active;

  logic        play;
  logic        high_half;
  logic [15:0] amp_pos;
  logic [15:0] amp_neg;
  logic [15:0] phase_inc;

  assign play      = tone_active && (samples_left != '0);
  assign high_half = phase_count < (period_len >> 1);
  assign amp_pos   = {1'b0, amp_level};
  assign amp_neg   = ~amp_pos + 16'd1;
  assign phase_inc = {1'b0, phase_count} + 16'd1;

  assign smp.valid = play;
  assign smp.last  = play && (samples_left == 21'd1);
  assign smp.value = play ? $signed(high_half ? amp_pos : amp_neg) : 16'sd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_left <= '0;
      period_len   <= stg_pkg::MIN_PERIOD;
      phase_count  <= '0;
      amp_level    <= '0;
      tone_active  <= 1'b0;
    end else if (load.valid) begin
      samples_left <= load.samples;
      period_len   <= load.period;
      phase_count  <= '0;
      amp_level    <= load.amp;
      tone_active  <= load.samples != '0;
    end else if (tick && play) begin
      phase_count  <= (phase_inc >= {1'b0, period_len}) ? 15'd0 : phase_inc[14:0];
      samples_left <= samples_left - 21'd1;
      if (samples_left == 21'd1) begin
        tone_active <= 1'b0;
      end
    end
  end

endmodule

/* design/square_tone_generator.sv */
// Top level of the square tone generator: command intake, start sequencer, sample output.
//
// Square-wave tone generator for a 22050 Hz audio stream. A command word with action START
// loads a tone from tone_freq (Hz), tone_length_ms and loudness (saturated at 100); a zero
// frequency or zero length leaves the current tone alone, and a valid start replaces any
// tone still playing. Every command word gives exactly one sample word. A START returns an
// all-zero sample word; a TICK returns the next stereo sample (+/- loudness*300, first half
// of the period positive) with last_sample set on the final one, or zeros when idle.
// Timing: after a TICK is taken, a new word can follow on the next cycle as long as the
// output register is free or being drained. A START that loads a tone keeps cmd.ready
// low until the tone is loaded: a single restoring divider, one quotient bit per cycle over
// 31 bits, is run twice (22050/freq for the period, then 22050*ms/1000 for the sample count),
// with the sequencer states and one registered multiply between the two passes.
module square_tone_generator (
  input  logic          clk,
  input  logic          rst,
  stg_cmd_if.sink       cmd,
  stg_smp_if.source     smp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PER_GO,
    S_PER_WAIT,
    S_MUL,
    S_LEN_GO,
    S_LEN_WAIT
  } state_t;

  state_t state;

  // Output register; it parts the command side from the sample side.
  logic                 out_valid;
  stg_pkg::stg_sample_t out_data;

  // Working registers of the start sequence (payload, no reset).
  logic [15:0] freq_q;
  logic [15:0] len_q;
  logic [14:0] amp_q;
  logic [14:0] period_q;
  logic [30:0] prod_q;

  logic                  accept;
  logic                  start_ok;
  logic [6:0]            vol_sat;
  logic [15:0]           amp_full;
  logic [14:0]           per_raw;
  stg_pkg::stg_div_req_t div_req;
  stg_pkg::stg_div_rsp_t div_rsp;
  stg_pkg::stg_load_t    load;
  stg_pkg::stg_sample_t  voice_smp;

  // Room in the output register: empty, or the held word leaves this cycle.
  assign cmd.ready = (state == S_IDLE) && (!out_valid || smp.ready);
  assign accept    = cmd.valid && cmd.ready;
  assign start_ok  = (cmd.tone_freq != '0) && (cmd.tone_length_ms != '0);

  assign vol_sat  = (cmd.loudness > {1'b0, stg_pkg::VOL_MAX}) ? stg_pkg::VOL_MAX
                                                              : cmd.loudness[6:0];
  assign amp_full = vol_sat * stg_pkg::AMP_STEP;

  // Period floor of two samples covers frequencies above half the sample rate.
  assign per_raw = div_rsp.quotient[14:0];

  // The divider is handed the period division first, the sample-count division second.
  always_comb begin
    div_req.start    = (state == S_PER_GO) || (state == S_LEN_GO);
    div_req.dividend = (state == S_PER_GO) ? 31'({16'd0, stg_pkg::TONE_RATE}) : prod_q;
    div_req.divisor  = (state == S_PER_GO) ? freq_q : stg_pkg::MS_PER_SEC;
  end

  assign load.valid   = (state == S_LEN_WAIT) && div_rsp.done;
  assign load.period  = period_q;
  assign load.samples = div_rsp.quotient[20:0];
  assign load.amp     = amp_q;

  stg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  stg_voice u_voice (
    .clk  (clk),
    .rst  (rst),
    .load (load),
    .tick (accept && (cmd.action == stg_pkg::ACT_TICK)),
    .smp  (voice_smp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (smp.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        out_valid <= 1'b1;
        out_data  <= (cmd.action == stg_pkg::ACT_TICK) ? voice_smp : '0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept && (cmd.action == stg_pkg::ACT_START) && start_ok) begin
            freq_q <= cmd.tone_freq;
            len_q  <= cmd.tone_length_ms;
            amp_q  <= amp_full[14:0];
            state  <= S_PER_GO;
          end
        end
        S_PER_GO: begin
          state <= S_PER_WAIT;
        end
        S_PER_WAIT: begin
          if (div_rsp.done) begin
            period_q <= (per_raw < stg_pkg::MIN_PERIOD) ? stg_pkg::MIN_PERIOD : per_raw;
            state    <= S_MUL;
          end
        end
        S_MUL: begin
          // 22050 * ms fits in 31 bits
          prod_q <= stg_pkg::TONE_RATE * len_q;
          state  <= S_LEN_GO;
        end
        S_LEN_GO: begin
          state <= S_LEN_WAIT;
        end
        S_LEN_WAIT: begin
          if (div_rsp.done) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign smp.valid        = out_valid;
  assign smp.left_sample  = out_data.value;
  assign smp.right_sample = out_data.value;
  assign smp.sample_valid = out_data.valid;
  assign smp.last_sample  = out_data.last;

endmodule

/* design/stg_chk.sv */
// Port-level checker for the square tone generator, bound to the top level.
module stg_chk (
  input logic        clk,
  input logic        rst,
  input logic        cmd_valid,
  input logic        cmd_ready,
  input logic        cmd_action,
  input logic [15:0] cmd_freq,
  input logic [15:0] cmd_len,
  input logic        smp_valid,
  input logic        smp_ready,
  input logic [15:0] smp_left,
  input logic        smp_sample_valid
);

  // A held sample word stays put until taken.
  assert property (@(posedge clk) disable iff (rst)
    smp_valid && !smp_ready |=> smp_valid && $stable(smp_left))
    else $error("sample word changed while stalled");

  // A command word is only taken when the output register has room.
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |-> !smp_valid || smp_ready)
    else $error("command taken with output register full");

  // A start gives an all-zero sample word on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd_action == stg_pkg::ACT_START)
    |=> smp_valid && !smp_sample_valid && (smp_left == 16'd0))
    else $error("start did not return a zero sample word");

  // A start that loads a tone keeps the command side busy while dividing.
  assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && (cmd_action == stg_pkg::ACT_START) &&
    (cmd_freq != 16'd0) && (cmd_len != 16'd0) |=> !cmd_ready)
    else $error("ready during tone set-up");

endmodule

bind square_tone_generator stg_chk u_stg_chk (
  .clk              (clk),
  .rst              (rst),
  .cmd_valid        (cmd.valid),
  .cmd_ready        (cmd.ready),
  .cmd_action       (cmd.action),
  .cmd_freq         (cmd.tone_freq),
  .cmd_len          (cmd.tone_length_ms),
  .smp_valid        (smp.valid),
  .smp_ready        (smp.ready),
  .smp_left         (smp.left_sample),
  .smp_sample_valid (smp.sample_valid)
);

/* dv/testbench.sv */
// Self-checking testbench for the square tone generator: directed and random command words.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Tone arithmetic constants, kept independent of the RTL.
  localparam int unsigned RATE_HZ      = 22050;
  localparam int unsigned MS_PER_S     = 1000;
  localparam int unsigned AMP_PER_STEP = 300;
  localparam int unsigned VOL_CAP      = 100;
  localparam int unsigned PERIOD_FLOOR = 2;

  localparam int unsigned ITEM_TARGET = 550;
  // A start holds the command side during tone set-up, and the receiver runs sparse stall
  // patterns and a long hold-off. The limit leaves wide margin.
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_TAIL  = 16;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    DRAIN_FULL,
    DRAIN_SKIP_QUARTER,
    DRAIN_COIN,
    DRAIN_SPARSE
  } drain_mode_t;

  typedef struct {
    logic        action;
    logic [15:0] freq;
    logic [15:0] len_ms;
    logic [7:0]  loud;
  } cmd_word_t;

  typedef struct packed {
    logic signed [15:0] left_val;
    logic signed [15:0] right_val;
    logic               audible;
    logic               last;
  } sample_word_t;

  logic clk = 1'b0;
  logic rst;

  stg_cmd_if cmd_ch ();
  stg_smp_if smp_ch ();

  square_tone_generator uut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .smp (smp_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted tone state, mirrors what the generator should hold.
  logic [20:0] tone_left   = '0;
  logic [14:0] tone_period = 15'd2;
  logic [14:0] tone_phase  = '0;
  logic [14:0] tone_amp    = '0;
  logic        tone_on     = 1'b0;

  sample_word_t expected_samples[$];

  int unsigned error_count = 0;
  int unsigned words_sent  = 0;
  int unsigned cycle_count = 0;

  // Sender burst control.
  int unsigned burst_left = 0;
  bit          gaps_on    = 1'b1;
  // Set by the pressure test, cleared by the receiver once the hold-off is done.
  bit          hold_off   = 1'b0;

  // Apply one command word to the predicted state; return the sample word it should give.
  function automatic sample_word_t play_word(input cmd_word_t w);
    sample_word_t r;
    int unsigned per;
    int unsigned vol;
    logic [15:0] s;
    r = '0;
    if (w.action == stg_pkg::ACT_START) begin
      // zero frequency or zero length: ignored, a running tone carries on
      if (w.freq != 0 && w.len_ms != 0) begin
        per = RATE_HZ / w.freq;
        if (per < PERIOD_FLOOR) per = PERIOD_FLOOR;   // above 11025 Hz
        vol = (w.loud > VOL_CAP) ? VOL_CAP : w.loud;  // loudness saturates at 100
        tone_left   = 21'(RATE_HZ * w.len_ms / MS_PER_S);
        tone_period = 15'(per);
        tone_phase  = '0;                              // restart phase on replace
        tone_amp    = 15'(vol * AMP_PER_STEP);
        tone_on     = (tone_left != 0);
      end
    end else if (tone_on && tone_left != 0) begin
      if (tone_phase < (tone_period >> 1)) s = {1'b0, tone_amp};
      else s = 16'd0 - {1'b0, tone_amp};
      r.left_val  = s;
      r.right_val = s;
      r.audible   = 1'b1;
      tone_phase  = tone_phase + 15'd1;
      if (tone_phase >= tone_period) tone_phase = '0;
      tone_left = tone_left - 21'd1;
      if (tone_left == 0) begin
        r.last  = 1'b1;
        tone_on = 1'b0;
      end
    end
    // tick while idle falls through with all zeros
    return r;
  endfunction

  function automatic cmd_word_t make_word(input logic act, input int unsigned freq,
                                          input int unsigned len_ms, input int unsigned loud);
    cmd_word_t w;
    w.action = act;
    w.freq   = freq[15:0];
    w.len_ms = len_ms[15:0];
    w.loud   = loud[7:0];
    return w;
  endfunction

  // Tick words carry random payload; the block must ignore it.
  function automatic cmd_word_t tick_word();
    return make_word(stg_pkg::ACT_TICK, $urandom, $urandom, $urandom);
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Offer one command word and wait for its handshake. Valid is only lowered during a gap,
  // so back-to-back words never see valid dropped and raised in the same step.
  task automatic send_word(input cmd_word_t w);
    if (gaps_on && burst_left == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
    end
    if (burst_left != 0) burst_left--;
    cmd_ch.valid          <= 1'b1;
    cmd_ch.action         <= w.action;
    cmd_ch.tone_freq      <= w.freq;
    cmd_ch.tone_length_ms <= w.len_ms;
    cmd_ch.loudness       <= w.loud;
    do @(posedge clk); while (!cmd_ch.ready);
    expected_samples.push_back(play_word(w));
    words_sent++;
  endtask

  task automatic send_ticks(input int unsigned n);
    repeat (n) send_word(tick_word());
  endtask

  // Compare one accepted sample word against the oldest prediction.
  task automatic check_sample();
    sample_word_t want;
    if (expected_samples.size() == 0) begin
      flag_error("sample word arrived with nothing expected");
    end else begin
      want = expected_samples.pop_front();
      if (smp_ch.left_sample !== want.left_val)
        flag_error($sformatf("left_sample %0d, want %0d", smp_ch.left_sample, want.left_val));
      if (smp_ch.right_sample !== want.right_val)
        flag_error($sformatf("right_sample %0d, want %0d", smp_ch.right_sample,
                             want.right_val));
      if (smp_ch.sample_valid !== want.audible)
        flag_error($sformatf("sample_valid %b, want %b", smp_ch.sample_valid, want.audible));
      if (smp_ch.last_sample !== want.last)
        flag_error($sformatf("last_sample %b, want %b", smp_ch.last_sample, want.last));
    end
  endtask

  // Output side: values read just after the edge are the ones the handshake saw.
  always @(posedge clk) begin
    if (!rst && smp_ch.valid && smp_ch.ready) check_sample();
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("square_tone_generator test failed");
      $finish;
    end
  end

  // Receiver: cycles through stall patterns, including long always-ready stretches. A
  // requested hold-off keeps ready low for HOLD_CYCLES, counted here.
  initial begin : sample_drain
    drain_mode_t mode;
    int unsigned mode_left;
    int unsigned beat;
    int unsigned held;
    logic take;
    mode      = DRAIN_FULL;
    mode_left = 100;
    beat      = 0;
    held      = 0;
    smp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        take = 1'b0;
        held++;
        if (held >= HOLD_CYCLES) begin
          hold_off = 1'b0;
          held     = 0;
        end
      end else begin
        if (mode_left == 0) begin
          mode      = drain_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        beat++;
        case (mode)
          DRAIN_FULL:         take = 1'b1;
          DRAIN_SKIP_QUARTER: take = (beat % 4) != 0;
          DRAIN_COIN:         take = 1'($urandom_range(0, 1));
          default:            take = (beat % 5) == 0;
        endcase
      end
      smp_ch.ready <= take;
    end
  end

  // Ticks while idle and starts that must be ignored.
  task automatic test_idle_ticks();
    send_word(tick_word());
    send_word(make_word(stg_pkg::ACT_START, 0, 500, 50));
    send_word(make_word(stg_pkg::ACT_START, 440, 0, 50));
    send_word(tick_word());
  endtask

  // Field extremes, ignored start mid-tone, replacement, and a tone played to its end.
  task automatic test_tone_extremes();
    send_word(make_word(stg_pkg::ACT_START, 65535, 1, 255));  // period floor, loudness saturates
    send_ticks(3);
    send_word(make_word(stg_pkg::ACT_START, 0, 0, 0));        // ignored, tone keeps going
    send_ticks(1);
    send_word(make_word(stg_pkg::ACT_START, 1, 65535, 0));    // longest period and length, silent
    send_ticks(2);
    send_word(make_word(stg_pkg::ACT_START, 11025, 1, 101));  // 22 samples, period 2
    send_ticks(23);                                           // runs past the last sample
  endtask

  // Receiver goes quiet for a long stretch while the sender keeps offering ticks.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    send_word(make_word(stg_pkg::ACT_START, 5512, 2, 77));
    hold_off = 1'b1;
    send_ticks(24);
    gaps_on = 1'b1;
  endtask

  // Mostly whole tones with random content; some cut short, ignored starts, and noise.
  task automatic test_random_tones();
    int unsigned pick;
    int unsigned freq;
    int unsigned len_ms;
    int unsigned tone_len;
    int unsigned n_ticks;
    while (words_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) freq = $urandom_range(1500, 11025);
        else if (pick < 85) freq = $urandom_range(11026, 65535);
        else freq = $urandom_range(1, 1499);
        len_ms   = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 65535)
                                               : $urandom_range(1, 3);
        tone_len = RATE_HZ * len_ms / MS_PER_S;
        send_word(make_word(stg_pkg::ACT_START, freq, len_ms, $urandom_range(0, 255)));
        if ($urandom_range(0, 4) == 0)
          n_ticks = $urandom_range(0, (tone_len < 30) ? tone_len : 30);  // replaced early
        else if (tone_len > 70)
          n_ticks = $urandom_range(0, 40);
        else
          n_ticks = tone_len + $urandom_range(0, 3);
        send_ticks(n_ticks);
      end else if (pick < 85) begin
        case ($urandom_range(0, 2))
          0:       send_word(make_word(stg_pkg::ACT_START, 0, $urandom, $urandom));
          1:       send_word(make_word(stg_pkg::ACT_START, $urandom, 0, $urandom));
          default: send_word(make_word(stg_pkg::ACT_START, 0, 0, $urandom));
        endcase
        send_ticks($urandom_range(0, 4));
      end else begin
        repeat ($urandom_range(1, 5))
          send_word(make_word($urandom_range(0, 1) ? stg_pkg::ACT_TICK : stg_pkg::ACT_START,
                              $urandom, $urandom, $urandom));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    cmd_ch.valid          <= 1'b0;
    cmd_ch.action         <= stg_pkg::ACT_TICK;
    cmd_ch.tone_freq      <= '0;
    cmd_ch.tone_length_ms <= '0;
    cmd_ch.loudness       <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_idle_ticks();
    test_tone_extremes();
    test_backpressure();
    test_random_tones();
    cmd_ch.valid <= 1'b0;

    // Every command word yields one sample word, so an empty queue means nothing pending.
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    if (error_count == 0) begin
      $display("square_tone_generator test passed");
    end else begin
      $display("square_tone_generator test failed");
    end
    $finish;
  end

endmodule
